### rtl/rau_pkg.sv
// rau_pkg: shared types and codes for the rational arithmetic unit.
// Used by rau_gcd, rau_div and rational_arith_unit_core; no dependencies.
package rau_pkg;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_CMP = 3'd4;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_ZDEN = 2'd1;
	localparam logic [1:0] STS_DIVZ = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

### rtl/rau_gcd.sv
// rau_gcd: iterative binary greatest common divisor, one subtract or shift per cycle.
// Depends on rau_pkg (unit_sts_t).
module rau_gcd #(
	parameter int PW = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PW-1:0]      a,
	input  logic [PW-1:0]      b,
	output logic [PW-1:0]      g,
	output rau_pkg::unit_sts_t sts
);

	localparam int KW = $clog2(PW + 1);

	logic [PW-1:0] u_q, v_q, g_q;
	logic [KW-1:0] k_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (u_q == '0 || v_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= a;
			v_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			if (u_q == '0) begin
				g_q <= v_q << k_q;
			end else if (v_q == '0) begin
				g_q <= u_q << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign g        = g_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### rtl/rau_div.sv
// rau_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg (unit_sts_t).
module rau_div #(
	parameter int PW = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PW-1:0]      n,
	input  logic [PW-1:0]      d,
	output logic [PW-1:0]      q,
	output rau_pkg::unit_sts_t sts
);

	localparam int CW = $clog2(PW) + 1;

	logic [PW:0]   rem_q, rem_sh;
	logic [PW-1:0] quo_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	assign rem_sh = {rem_q[PW-1:0], quo_q[PW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(PW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
			d_q   <= d;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (rem_sh >= {1'b0, d_q}) begin
				rem_q <= rem_sh - {1'b0, d_q};
				quo_q <= {quo_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[PW-2:0], 1'b0};
			end
		end
	end

	assign q        = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### rtl/rational_arith_unit_core.sv
// rational_arith_unit_core: exact fraction add, subtract, multiply, divide and compare.
// Depends on rau_pkg, rau_gcd and rau_div.
//
//   channel | dir | tdata                                    | tuser
//   s_axis  | in  | a_num, a_den, b_num, b_den (32 b each)   | cmd
//   m_axis  | out | res_num, res_den, less, equal, greater   | status
//
// An item takes up to three reductions, each a binary gcd (with 2*OPERAND_BITS-bit
// operands in the last one) and two bit-serial divisions, plus three products from the
// shared multiplier. Compare and division by zero skip the last reduction. A zero
// denominator or an unused command goes straight to the done state. No input is taken while busy.
// Reset clears the sequencer and the output valid; a stalled result holds the
// sequencer before the next load of the output register.
module rational_arith_unit_core #(
	parameter int OPERAND_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
	input  logic [127:0] s_axis_tdata,
	// cmd[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// res_num[63:0], res_den[126:64], less[127], equal[128], greater[129], zero pad
	output logic [135:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	localparam int W  = OPERAND_BITS;
	localparam int PW = 2 * OPERAND_BITS;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_GCD_GO  = 4'd1;
	localparam logic [3:0] ST_GCD_W   = 4'd2;
	localparam logic [3:0] ST_DIVN_GO = 4'd3;
	localparam logic [3:0] ST_DIVN_W  = 4'd4;
	localparam logic [3:0] ST_DIVD_GO = 4'd5;
	localparam logic [3:0] ST_DIVD_W  = 4'd6;
	localparam logic [3:0] ST_POST    = 4'd7;
	localparam logic [3:0] ST_MUL     = 4'd8;
	localparam logic [3:0] ST_COMB    = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	logic [3:0]    st_q;
	logic [1:0]    phase_q, m_q;
	logic [2:0]    cmd_q;
	logic          a_neg_q, b_neg_q, r_neg_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic [PW-1:0] p0_q, p1_q, p2_q, x_q, y_q;
	logic          lt_q, eq_q, gt_q;
	logic [1:0]    sts_q;

	logic          ov_q;
	logic [63:0]   o_num_q;
	logic [62:0]   o_den_q;
	logic          o_lt_q, o_eq_q, o_gt_q;
	logic [1:0]    o_sts_q;

	logic [W-1:0]  in_an, in_ad, in_bn, in_bd;
	logic [W-1:0]  anm, adm, bnm, bdm;
	logic          an_s, ad_s, bn_s, bd_s;

	assign in_an = s_axis_tdata[W-1:0];
	assign in_ad = s_axis_tdata[32+W-1:32];
	assign in_bn = s_axis_tdata[64+W-1:64];
	assign in_bd = s_axis_tdata[96+W-1:96];
	assign an_s  = in_an[W-1];
	assign ad_s  = in_ad[W-1];
	assign bn_s  = in_bn[W-1];
	assign bd_s  = in_bd[W-1];
	assign anm   = an_s ? (~in_an + 1'b1) : in_an;
	assign adm   = ad_s ? (~in_ad + 1'b1) : in_ad;
	assign bnm   = bn_s ? (~in_bn + 1'b1) : in_bn;
	assign bdm   = bd_s ? (~in_bd + 1'b1) : in_bd;

	logic               gcd_start, div_start;
	logic [PW-1:0]      g, div_n, div_q;
	rau_pkg::unit_sts_t gcd_sts, div_sts;

	assign gcd_start = (st_q == ST_GCD_GO);
	assign div_start = (st_q == ST_DIVN_GO) || (st_q == ST_DIVD_GO);
	assign div_n     = (st_q == ST_DIVN_GO) ? x_q : y_q;

	rau_gcd #(.PW(PW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (x_q),
		.b      (y_q),
		.g      (g),
		.sts    (gcd_sts)
	);

	rau_div #(.PW(PW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (g),
		.q      (div_q),
		.sts    (div_sts)
	);

	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] prod;

	always_comb begin
		case (m_q)
			2'd0: begin
				mul_a = an_q;
				mul_b = (cmd_q == rau_pkg::CMD_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (cmd_q == rau_pkg::CMD_DIV) ? bn_q : bd_q;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	logic          s1, s2, rneg;
	logic [PW-1:0] rnum;

	always_comb begin
		s1 = a_neg_q && (p0_q != '0);
		s2 = ((cmd_q == rau_pkg::CMD_SUB) ? !b_neg_q : b_neg_q) && (p1_q != '0);
		if (cmd_q == rau_pkg::CMD_MUL || cmd_q == rau_pkg::CMD_DIV) begin
			rnum = p0_q;
			rneg = a_neg_q ^ b_neg_q;
		end else if (s1 == s2) begin
			rnum = p0_q + p1_q;
			rneg = s1;
		end else if (p0_q >= p1_q) begin
			rnum = p0_q - p1_q;
			rneg = s1;
		end else begin
			rnum = p1_q - p0_q;
			rneg = s2;
		end
	end

	logic c_lt, c_eq, c_gt;

	always_comb begin
		c_eq = 1'b0;
		c_lt = 1'b0;
		c_gt = 1'b0;
		if ((a_neg_q && p0_q != '0) != (b_neg_q && p1_q != '0)) begin
			c_lt = a_neg_q && p0_q != '0;
			c_gt = !c_lt;
		end else if (p0_q == p1_q) begin
			c_eq = 1'b1;
		end else if (!(a_neg_q && p0_q != '0)) begin
			c_lt = p0_q < p1_q;
			c_gt = !c_lt;
		end else begin
			c_lt = p0_q > p1_q;
			c_gt = !c_lt;
		end
	end

	assign s_axis_tready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= 2'd0;
			m_q     <= 2'd0;
			ov_q    <= 1'b0;
		end else begin
			if (st_q == ST_DONE && (!ov_q || m_axis_tready))
				ov_q <= 1'b1;
			else if (m_axis_tready)
				ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						phase_q <= 2'd0;
						if (s_axis_tuser > rau_pkg::CMD_CMP || adm == '0 || bdm == '0)
							st_q <= ST_DONE;
						else
							st_q <= ST_GCD_GO;
					end
				end
				ST_GCD_GO:  st_q <= ST_GCD_W;
				ST_GCD_W:   if (gcd_sts.done) st_q <= ST_DIVN_GO;
				ST_DIVN_GO: st_q <= ST_DIVN_W;
				ST_DIVN_W:  if (div_sts.done) st_q <= ST_DIVD_GO;
				ST_DIVD_GO: st_q <= ST_DIVD_W;
				ST_DIVD_W:  if (div_sts.done) st_q <= ST_POST;
				ST_POST: begin
					case (phase_q)
						2'd0: begin
							phase_q <= 2'd1;
							st_q    <= ST_GCD_GO;
						end
						2'd1: begin
							m_q <= 2'd0;
							if (cmd_q == rau_pkg::CMD_DIV && x_q == '0)
								st_q <= ST_DONE;
							else
								st_q <= ST_MUL;
						end
						default: st_q <= ST_DONE;
					endcase
				end
				ST_MUL: begin
					if (m_q == 2'd2) begin
						st_q <= ST_COMB;
					end else begin
						m_q <= m_q + 2'd1;
					end
				end
				ST_COMB: begin
					if (cmd_q == rau_pkg::CMD_CMP) begin
						st_q <= ST_DONE;
					end else begin
						phase_q <= 2'd2;
						st_q    <= ST_GCD_GO;
					end
				end
				ST_DONE: begin
					if (!ov_q || m_axis_tready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				cmd_q   <= s_axis_tuser;
				x_q     <= PW'(anm);
				y_q     <= PW'(adm);
				bn_q    <= bnm;
				bd_q    <= bdm;
				a_neg_q <= an_s ^ ad_s;
				b_neg_q <= bn_s ^ bd_s;
				lt_q    <= 1'b0;
				eq_q    <= 1'b0;
				gt_q    <= 1'b0;
				sts_q   <= rau_pkg::STS_OK;
				if (s_axis_tuser > rau_pkg::CMD_CMP) begin
					x_q <= '0;
					y_q <= '0;
				end else if (adm == '0 || bdm == '0) begin
					x_q   <= '0;
					y_q   <= '0;
					sts_q <= rau_pkg::STS_ZDEN;
				end
			end
			ST_DIVN_W: if (div_sts.done) x_q <= div_q;
			ST_DIVD_W: if (div_sts.done) y_q <= div_q;
			ST_POST: begin
				case (phase_q)
					2'd0: begin
						an_q    <= x_q[W-1:0];
						ad_q    <= y_q[W-1:0];
						a_neg_q <= a_neg_q && (x_q != '0);
						x_q     <= PW'(bn_q);
						y_q     <= PW'(bd_q);
					end
					2'd1: begin
						bn_q    <= x_q[W-1:0];
						bd_q    <= y_q[W-1:0];
						b_neg_q <= b_neg_q && (x_q != '0);
						if (cmd_q == rau_pkg::CMD_DIV && x_q == '0) begin
							x_q   <= '0;
							y_q   <= '0;
							sts_q <= rau_pkg::STS_DIVZ;
						end
					end
					default: begin
						if (r_neg_q)
							x_q <= ~x_q + 1'b1;
					end
				endcase
			end
			ST_MUL: begin
				case (m_q)
					2'd0:    p0_q <= prod;
					2'd1:    p1_q <= prod;
					default: p2_q <= prod;
				endcase
			end
			ST_COMB: begin
				if (cmd_q == rau_pkg::CMD_CMP) begin
					lt_q <= c_lt;
					eq_q <= c_eq;
					gt_q <= c_gt;
					x_q  <= '0;
					y_q  <= '0;
				end else begin
					x_q     <= rnum;
					y_q     <= p2_q;
					r_neg_q <= rneg;
				end
			end
			ST_DONE: begin
				if (!ov_q || m_axis_tready) begin
					o_num_q <= 64'(signed'(x_q));
					o_den_q <= 63'(y_q);
					o_lt_q  <= lt_q;
					o_eq_q  <= eq_q;
					o_gt_q  <= gt_q;
					o_sts_q <= sts_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {6'd0, o_gt_q, o_eq_q, o_lt_q, o_den_q, o_num_q};
	assign m_axis_tuser  = o_sts_q;

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && ov_q && !m_axis_tready) |=> (st_q == ST_DONE))
		else $error("sequencer left done while result stalled");

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0({o_lt_q, o_eq_q, o_gt_q}))
		else $error("more than one compare flag set");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && o_sts_q != rau_pkg::STS_OK) |-> (o_num_q == '0 && o_den_q == '0))
		else $error("error result carries nonzero fraction");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (!gcd_sts.busy && !div_sts.busy))
		else $error("arithmetic unit busy while idle");

endmodule

### dv/testbench.sv
// testbench: self-checking bench for rational_arith_unit_core.
// Drives fraction operations on the input stream and checks each result in order
// against a scoreboard; depends on rau_pkg and the core RTL.
module testbench;

	typedef struct packed {
		logic [63:0] num;
		logic [62:0] den;
		logic        lt;
		logic        eq;
		logic        gt;
		logic [1:0]  sts;
	} frac_res_t;

	class frac_scoreboard;
		frac_res_t pending[$];
		int errors = 0;

		function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
			logic [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function void shrink(ref logic neg, ref logic [63:0] n, ref logic [63:0] d);
			logic [63:0] g;
			g = gcd64(n, d);
			if (g == 0) g = 1;
			n = n / g;
			d = d / g;
			if (n == 0) neg = 0;
		endfunction

		function logic [63:0] mag(logic [31:0] raw, output logic neg);
			neg = raw[31];
			return raw[31] ? 64'(-$signed({32'hffffffff, raw})) : {32'd0, raw};
		endfunction

		function void note_input(logic [2:0] op, logic [31:0] an_r, logic [31:0] ad_r,
		                         logic [31:0] bn_r, logic [31:0] bd_r);
			frac_res_t r;
			logic an_s, ad_s, bn_s, bd_s, an_g, bn_g, s1, s2, rneg;
			logic [63:0] an, ad, bn, bd, t1, t2, rn, rd;
			r = '0;
			an = mag(an_r, an_s);
			ad = mag(ad_r, ad_s);
			bn = mag(bn_r, bn_s);
			bd = mag(bd_r, bd_s);
			if (op > rau_pkg::CMD_CMP) begin
				pending.push_back(r);
				return;
			end
			if (ad == 0 || bd == 0) begin
				r.sts = rau_pkg::STS_ZDEN;
				pending.push_back(r);
				return;
			end
			an_g = an_s ^ ad_s;
			bn_g = bn_s ^ bd_s;
			shrink(an_g, an, ad);
			shrink(bn_g, bn, bd);
			t1 = an * bd;
			t2 = bn * ad;
			rneg = 0;
			rd = ad * bd;
			if (op == rau_pkg::CMD_CMP) begin
				s1 = (t1 == 0) ? 0 : an_g;
				s2 = (t2 == 0) ? 0 : bn_g;
				if (s1 != s2) begin
					r.lt = s1;
					r.gt = !s1;
				end else if (t1 == t2) r.eq = 1;
				else if (!s1) begin
					r.lt = t1 < t2;
					r.gt = t1 > t2;
				end else begin
					r.lt = t1 > t2;
					r.gt = t1 < t2;
				end
				pending.push_back(r);
				return;
			end
			if (op == rau_pkg::CMD_ADD || op == rau_pkg::CMD_SUB) begin
				s1 = (t1 == 0) ? 0 : an_g;
				s2 = (t2 == 0) ? 0 : ((op == rau_pkg::CMD_SUB) ? !bn_g : bn_g);
				if (s1 == s2) begin
					rn = t1 + t2;
					rneg = s1;
				end else if (t1 >= t2) begin
					rn = t1 - t2;
					rneg = s1;
				end else begin
					rn = t2 - t1;
					rneg = s2;
				end
			end else if (op == rau_pkg::CMD_MUL) begin
				rn = an * bn;
				rneg = an_g ^ bn_g;
			end else begin
				if (bn == 0) begin
					r.sts = rau_pkg::STS_DIVZ;
					pending.push_back(r);
					return;
				end
				rn = t1;
				rd = ad * bn;
				rneg = an_g ^ bn_g;
			end
			shrink(rneg, rn, rd);
			r.num = rneg ? -rn : rn;
			r.den = rd[62:0];
			pending.push_back(r);
		endfunction

		function void check_result(frac_res_t got);
			frac_res_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.num !== exp_r.num) begin
				$display("%0t: res_num exp %h got %h", $time, exp_r.num, got.num);
				errors++;
			end
			if (got.den !== exp_r.den) begin
				$display("%0t: res_den exp %h got %h", $time, exp_r.den, got.den);
				errors++;
			end
			if ({got.lt, got.eq, got.gt} !== {exp_r.lt, exp_r.eq, exp_r.gt}) begin
				$display("%0t: lt/eq/gt exp %b got %b", $time,
					{exp_r.lt, exp_r.eq, exp_r.gt}, {got.lt, got.eq, got.gt});
				errors++;
			end
			if (got.sts !== exp_r.sts) begin
				$display("%0t: status exp %0d got %0d", $time, exp_r.sts, got.sts);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [135:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	frac_scoreboard sb = new();
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	always #5 clk = ~clk;

	rational_arith_unit_core dut (.*);

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result({m_axis_tdata[63:0],
				m_axis_tdata[126:64], m_axis_tdata[127], m_axis_tdata[128],
				m_axis_tdata[129], m_axis_tuser});
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		int mode;
		forever begin
			@(negedge clk);
			if (hold_off) m_axis_tready <= 0;
			else begin
				mode = $urandom_range(0, 3);
				m_axis_tready <= (mode == 0) ? ($urandom_range(0, 7) == 0) :
					(mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			end
		end
	end

	task automatic send_op(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
	                       logic [31:0] bn, logic [31:0] bd);
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {bd, bn, ad, an};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(op, an, ad, bn, bd);
		@(negedge clk);
	endtask

	task automatic drop_valid(int n);
		s_axis_tvalid <= 0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 8) - 4;
			1: return 32'h80000000;
			2: return 32'h7fffffff;
			3: return $urandom_range(1, 1000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [2:0] op;
		logic [31:0] n_a, d_a, n_b, d_b;
		int burst;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_op(rau_pkg::CMD_ADD, 1, 2, 1, 3);
		send_op(rau_pkg::CMD_SUB, 1, 2, 1, 2);
		send_op(rau_pkg::CMD_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000, 1);
		send_op(rau_pkg::CMD_DIV, 3, -4, -5, 7);
		send_op(rau_pkg::CMD_DIV, 3, 4, 0, 7);
		send_op(rau_pkg::CMD_CMP, 1, 3, 1, 2);
		send_op(rau_pkg::CMD_CMP, 2, 4, -1, -2);
		send_op(rau_pkg::CMD_CMP, -1, 2, 1, -3);
		send_op(rau_pkg::CMD_CMP, 0, 5, 0, -3);
		send_op(rau_pkg::CMD_ADD, 1, 0, 1, 1);
		send_op(rau_pkg::CMD_CMP, 1, 1, 1, 0);
		send_op(3'd5, 1, 1, 1, 1);
		send_op(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_op(rau_pkg::CMD_ADD, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
		send_op(rau_pkg::CMD_SUB, 32'h7fffffff, 1, 32'h80000000, 1);
		send_op(rau_pkg::CMD_MUL, 0, -7, 5, 9);
		send_op(rau_pkg::CMD_DIV, 32'h80000000, 3, 32'h80000000, 32'h7fffffff);
		send_op(rau_pkg::CMD_ADD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		drop_valid(1);
		hold_off = 1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			repeat (4) send_op(rau_pkg::CMD_MUL, $urandom, $urandom | 1, $urandom,
				$urandom | 1);
		join
		drop_valid(1);
		while (sb.pending.size() != 0) @(negedge clk);
		for (int i = 0; i < 140; i++) begin
			burst = $urandom_range(1, 6);
			for (int k = 0; k < burst; k++) begin
				op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) :
					3'($urandom_range(0, 4));
				n_a = rand_val();
				n_b = rand_val();
				d_a = rand_val();
				d_b = rand_val();
				if ($urandom_range(0, 15) != 0 && d_a == 0) d_a = 1;
				if ($urandom_range(0, 15) != 0 && d_b == 0) d_b = -1;
				send_op(op, n_a, d_a, n_b, d_b);
			end
			if ($urandom_range(0, 1) == 0)
				drop_valid($urandom_range(1, 40));
		end
		drop_valid(1);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
